>>> rtl/core/stps_pkg.sv
// Shared types and constants of the square-tunnel pixel shader.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package stps_pkg;

  localparam int IDX_BITS       = 8;
  localparam int COLOR_BITS     = 16;
  localparam int SCALE_BITS     = 16;
  localparam int PAL_ENTRIES    = 256;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int SWIRL_SHIFT    = 2;

  localparam int X_BITS_DEFAULT = 9;
  localparam int Y_BITS_DEFAULT = 8;

  localparam logic [SCALE_BITS-1:0] PERSP_K_RESET = 16'd3000;
  localparam logic [31:0]           VP_COL_RESET  = 32'd160;
  localparam logic [31:0]           VP_ROW_RESET  = 32'd120;
  localparam logic [IDX_BITS-1:0]   Z_SHIFT_RESET = 8'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PERSP_K = 2'd0,
    CFG_VP_COL  = 2'd1,
    CFG_VP_ROW  = 2'd2,
    CFG_Z_SHIFT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_SHADE = 1'b1
  } func_t;

endpackage

`default_nettype wire

>>> rtl/core/square_tunnel_pixel_shader_unit.sv
// Square-tunnel pixel shader: distance, pipelined divider, index and palette.
// Depends on stps_pkg.
//
// The slave stream carries one item per transfer. tuser selects the kind: a
// load item writes entry_color into palette slot entry_index and gives no
// result, a shade item carries pix_x and pix_y and gives one result on the
// master stream with the palette index and the RGB565 color found there.
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle; the block does not enforce
// it. The work runs through 21 register stages: input, distance differences,
// distance, sixteen restoring divider steps (one quotient bit each), index, and
// the palette read. With the output free, one item is taken every cycle. Load
// items travel the same stages and write the palette in the read stage, so a
// pixel always sees every load given before it. After reset all valid bits are
// clear and the palette holds unknown data until loaded. A stalled receiver
// fills the output register and then one skid register; the input keeps
// taking items until the skid register is full, and then the pipeline holds.
`default_nettype none

module square_tunnel_pixel_shader_unit #(
  parameter int X_BITS = stps_pkg::X_BITS_DEFAULT,
  parameter int Y_BITS = stps_pkg::Y_BITS_DEFAULT,
  localparam int IN_W  = ((X_BITS + Y_BITS + stps_pkg::IDX_BITS + stps_pkg::COLOR_BITS + 7) / 8)
                         * 8,
  localparam int OUT_W = ((stps_pkg::IDX_BITS + stps_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [stps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [stps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pix_x, pix_y, entry_index, entry_color, zero fill
  input  wire logic [IN_W-1:0]                     s_axis_tdata,
  // func
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // color_index, pixel_color
  output logic [OUT_W-1:0]                         m_axis_tdata
);
  import stps_pkg::*;

  localparam int DIST_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int REM_BITS  = DIST_BITS + 1;
  localparam int DIV_STEPS = SCALE_BITS;
  localparam int PY_LO     = X_BITS;
  localparam int IX_LO     = X_BITS + Y_BITS;
  localparam int COL_LO    = IX_LO + IDX_BITS;

  logic [SCALE_BITS-1:0] persp_k;
  logic [X_BITS-1:0]     vp_col;
  logic [Y_BITS-1:0]     vp_row;
  logic [IDX_BITS-1:0]   z_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      persp_k <= PERSP_K_RESET;
      vp_col  <= VP_COL_RESET[X_BITS-1:0];
      vp_row  <= VP_ROW_RESET[Y_BITS-1:0];
      z_shift <= Z_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PERSP_K: persp_k <= cfg_data[SCALE_BITS-1:0];
        CFG_VP_COL:  vp_col  <= cfg_data[X_BITS-1:0];
        CFG_VP_ROW:  vp_row  <= cfg_data[Y_BITS-1:0];
        CFG_Z_SHIFT: z_shift <= cfg_data[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // Input stage.
  logic                  v0;
  func_t                 f0;
  logic [X_BITS-1:0]     px0;
  logic [Y_BITS-1:0]     py0;
  logic [IDX_BITS-1:0]   ix0;
  logic [COLOR_BITS-1:0] col0;

  // Distance differences.
  logic                  v1;
  func_t                 f1;
  logic [X_BITS-1:0]     dx1;
  logic [Y_BITS-1:0]     dy1;
  logic [IDX_BITS-1:0]   ix1;
  logic [COLOR_BITS-1:0] col1;

  // Divider stages; element 0 is the distance stage.
  logic                  dv   [DIV_STEPS+1];
  func_t                 dfunc[DIV_STEPS+1];
  logic [DIST_BITS-1:0]  ddist[DIV_STEPS+1];
  logic [DIST_BITS-1:0]  drem [DIV_STEPS+1];
  logic [IDX_BITS-1:0]   dq   [DIV_STEPS+1];
  logic [IDX_BITS-1:0]   dix  [DIV_STEPS+1];
  logic [COLOR_BITS-1:0] dcol [DIV_STEPS+1];

  // Index stage.
  logic                  vi;
  func_t                 fi;
  logic [IDX_BITS-1:0]   idx_i;
  logic [COLOR_BITS-1:0] col_i;

  // Palette read stage.
  logic                  vr;
  func_t                 fr;
  logic [IDX_BITS-1:0]   idx_r;
  logic [COLOR_BITS-1:0] col_r;

  logic [COLOR_BITS-1:0] palette[PAL_ENTRIES];

  logic [DIST_BITS-1:0]  dist_max;
  logic [IDX_BITS-1:0]   depth;
  logic [IDX_BITS-1:0]   depth_sum;
  logic [IDX_BITS-1:0]   pal_idx;

  always_comb begin
    if (DIST_BITS'(dx1) >= DIST_BITS'(dy1)) begin
      dist_max = DIST_BITS'(dx1);
    end else begin
      dist_max = DIST_BITS'(dy1);
    end
    depth     = dq[DIV_STEPS];
    depth_sum = depth + z_shift;
    pal_idx   = depth_sum ^ (depth >> SWIRL_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      dv[0] <= 1'b0;
      vi    <= 1'b0;
      vr    <= 1'b0;
    end else if (en) begin
      v0    <= s_axis_tvalid;
      v1    <= v0;
      dv[0] <= v1;
      vi    <= dv[DIV_STEPS];
      vr    <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0   <= func_t'(s_axis_tuser);
      px0  <= s_axis_tdata[X_BITS-1:0];
      py0  <= s_axis_tdata[PY_LO +: Y_BITS];
      ix0  <= s_axis_tdata[IX_LO +: IDX_BITS];
      col0 <= s_axis_tdata[COL_LO +: COLOR_BITS];

      f1   <= f0;
      dx1  <= (px0 >= vp_col) ? (px0 - vp_col) : (vp_col - px0);
      dy1  <= (py0 >= vp_row) ? (py0 - vp_row) : (vp_row - py0);
      ix1  <= ix0;
      col1 <= col0;

      dfunc[0] <= f1;
      ddist[0] <= (dist_max == '0) ? DIST_BITS'(1) : dist_max;
      drem[0]  <= '0;
      dq[0]    <= '0;
      dix[0]   <= ix1;
      dcol[0]  <= col1;

      fi    <= dfunc[DIV_STEPS];
      idx_i <= (dfunc[DIV_STEPS] == FUNC_LOAD) ? dix[DIV_STEPS] : pal_idx;
      col_i <= dcol[DIV_STEPS];

      if (vi && fi == FUNC_LOAD) begin
        palette[idx_i] <= col_i;
      end
      fr    <= fi;
      idx_r <= idx_i;
      col_r <= palette[idx_i];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_BITS-1:0] shifted;
    logic [REM_BITS-1:0] diff;
    logic                take;

    always_comb begin
      shifted = {drem[k], persp_k[DIV_STEPS-1-k]};
      diff    = shifted - {1'b0, ddist[k]};
      take    = shifted >= {1'b0, ddist[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dfunc[k+1] <= dfunc[k];
        ddist[k+1] <= ddist[k];
        drem[k+1]  <= take ? diff[DIST_BITS-1:0] : shifted[DIST_BITS-1:0];
        dq[k+1]    <= {dq[k][IDX_BITS-2:0], take};
        dix[k+1]   <= dix[k];
        dcol[k+1]  <= dcol[k];
      end
    end
  end

  // Output register with one skid register behind it.
  logic                  res_valid;
  logic                  out_valid;
  logic [IDX_BITS-1:0]   out_idx;
  logic [COLOR_BITS-1:0] out_color;
  logic [IDX_BITS-1:0]   skid_idx;
  logic [COLOR_BITS-1:0] skid_color;
  logic                  out_free;

  assign res_valid = vr && (fr == FUNC_SHADE);
  assign out_free  = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (en && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_idx   <= skid_idx;
        out_color <= skid_color;
      end else begin
        out_idx   <= idx_r;
        out_color <= col_r;
      end
    end else if (en) begin
      skid_idx   <= idx_r;
      skid_color <= col_r;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_color, out_idx});

endmodule

`default_nettype wire

>>> rtl/core/stps_checker.sv
// Port-level checks of the square-tunnel pixel shader, bound to its top level.
// Depends on stps_pkg and square_tunnel_pixel_shader_unit.
`default_nettype none

module stps_checker #(
  parameter int X_BITS = stps_pkg::X_BITS_DEFAULT,
  parameter int Y_BITS = stps_pkg::Y_BITS_DEFAULT,
  localparam int OUT_W = ((stps_pkg::IDX_BITS + stps_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);
  import stps_pkg::*;

  localparam int IN_BITS = X_BITS + Y_BITS + IDX_BITS + COLOR_BITS;

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset (input field bits %0d)", IN_BITS);

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  a_stall_only_behind_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !s_axis_tready |=> s_axis_tready)
    else $error("input still stalled after the waiting result was taken");

endmodule

bind square_tunnel_pixel_shader_unit stps_checker #(
  .X_BITS(X_BITS),
  .Y_BITS(Y_BITS)
) u_stps_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

>>> sim/tb_square_tunnel_pixel_shader_unit.sv
// Testbench for square_tunnel_pixel_shader_unit: streams palette loads and pixels,
// predicts each pixel result in order and checks it on the master stream.
// Depends on stps_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb_square_tunnel_pixel_shader_unit;
  import stps_pkg::*;

  localparam int XW = X_BITS_DEFAULT;
  localparam int YW = Y_BITS_DEFAULT;
  localparam int SETTLE_CYCLES = 32;

  typedef struct packed {
    logic [IDX_BITS-1:0]   color_index;
    logic [COLOR_BITS-1:0] pixel_color;
  } shaded_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // pix_x, pix_y, entry_index, entry_color, zero fill
  logic [47:0] s_axis_tdata = '0;
  // func
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // color_index, pixel_color
  logic [23:0] m_axis_tdata;

  logic [SCALE_BITS-1:0] persp_k_r = PERSP_K_RESET;
  logic [XW-1:0] vp_col_r = VP_COL_RESET[XW-1:0];
  logic [YW-1:0] vp_row_r = VP_ROW_RESET[YW-1:0];
  logic [IDX_BITS-1:0] z_shift_r = Z_SHIFT_RESET;
  logic [COLOR_BITS-1:0] palette_copy [PAL_ENTRIES];

  shaded_pixel_t shaded_q [$];
  int fail_count = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int sink_hold = 0;

  square_tunnel_pixel_shader_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [IDX_BITS-1:0] tunnel_index(input logic [XW-1:0] px,
                                                       input logic [YW-1:0] py);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    logic [XW-1:0] cheb;
    logic [SCALE_BITS-1:0] quot;
    logic [IDX_BITS-1:0] depth;
    dx = (px >= vp_col_r) ? px - vp_col_r : vp_col_r - px;
    dy = (py >= vp_row_r) ? py - vp_row_r : vp_row_r - py;
    cheb = (XW'(dy) > dx) ? XW'(dy) : dx;
    if (cheb == '0) begin
      cheb = XW'(1);
    end
    quot = persp_k_r / SCALE_BITS'(cheb);
    depth = quot[IDX_BITS-1:0];
    return (depth + z_shift_r) ^ (depth >> SWIRL_SHIFT);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic stream_item(input func_t kind, input logic [XW-1:0] x, input logic [YW-1:0] y,
                             input logic [IDX_BITS-1:0] slot,
                             input logic [COLOR_BITS-1:0] color);
    int gap;
    logic [IDX_BITS-1:0] idx;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, color, slot, y, x};
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == FUNC_LOAD) begin
      palette_copy[slot] = color;
    end else begin
      idx = tunnel_index(x, y);
      shaded_q.push_back('{color_index: idx, pixel_color: palette_copy[idx]});
    end
  endtask

  task automatic shade(input logic [XW-1:0] x, input logic [YW-1:0] y);
    stream_item(FUNC_SHADE, x, y, IDX_BITS'($urandom), COLOR_BITS'($urandom));
  endtask

  task automatic load(input logic [IDX_BITS-1:0] slot, input logic [COLOR_BITS-1:0] color);
    stream_item(FUNC_LOAD, XW'($urandom), YW'($urandom), slot, color);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shaded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t reg_sel, input logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (reg_sel)
      CFG_PERSP_K: persp_k_r = value;
      CFG_VP_COL:  vp_col_r = value[XW-1:0];
      CFG_VP_ROW:  vp_row_r = value[YW-1:0];
      CFG_Z_SHIFT: z_shift_r = value[IDX_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] scale, input logic [15:0] cx,
                           input logic [15:0] cy, input logic [15:0] zs);
    write_reg(CFG_PERSP_K, scale);
    write_reg(CFG_VP_COL, cx);
    write_reg(CFG_VP_ROW, cy);
    write_reg(CFG_Z_SHIFT, zs);
  endtask

  // Every palette slot is loaded before any pixel can select it.
  task automatic test_palette_fill();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      load(IDX_BITS'(i), (i == 0) ? 16'h0000 : (i == 255) ? 16'hFFFF : COLOR_BITS'($urandom));
    end
  endtask

  task automatic test_reset_config();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    shade(VP_COL_RESET[XW-1:0], VP_ROW_RESET[YW-1:0]);
    shade(VP_COL_RESET[XW-1:0] + XW'(1), VP_ROW_RESET[YW-1:0]);
    shade('0, '0);
    shade('1, '1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    shade('1, '1);
    shade('0, '0);
    shade('1, '0);
    drain();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0080);
    shade('0, '0);
    shade('1, '1);
    drain();
    write_all(16'h0001, 16'h00FF, 16'h0080, 16'h0000);
    shade(9'd255, 8'd128);
    shade('0, '1);
    drain();
  endtask

  // A pixel must see a load given just before it, even back to back.
  task automatic test_load_forwarding();
    logic [IDX_BITS-1:0] slot;
    write_all(16'd3000, 16'd160, 16'd120, 16'd7);
    slot = tunnel_index(9'd170, 8'd125);
    load(slot, 16'hA5A5);
    shade(9'd170, 8'd125);
    load(slot, 16'h5A5A);
    shade(9'd170, 8'd125);
    load(8'd0, 16'hFFFF);
    load(8'd255, 16'h0000);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_all((p == 3) ? 16'($urandom_range(0, 255)) : 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
      src_gaps = (p != 0) && (p != 2);
      sink_stalls = (p != 0) && (p != 1);
      for (int i = 0; i < 254; i++) begin
        if ($urandom_range(0, 99) < 30) begin
          load(IDX_BITS'($urandom), COLOR_BITS'($urandom));
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            x = vp_col_r + XW'($urandom_range(0, 16)) - XW'(8);
            y = vp_row_r + YW'($urandom_range(0, 16)) - YW'(8);
          end else begin
            x = XW'($urandom);
            y = YW'($urandom);
          end
          shade(x, y);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    shaded_pixel_t exp_pix;
    shaded_pixel_t got_pix;
    if (!rst) begin
      if (!sink_stalls) begin
        m_axis_tready <= 1'b1;
      end else if (sink_hold != 0) begin
        sink_hold <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  m_axis_tready <= 1'b1;
          [70:94]: begin
            m_axis_tready <= 1'b0;
            sink_hold <= $urandom_range(0, 2);
          end
          default: begin
            m_axis_tready <= 1'b0;
            sink_hold <= $urandom_range(10, 40);
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_pix = {m_axis_tdata[7:0], m_axis_tdata[23:8]};
        if (shaded_q.size() == 0) begin
          $error("result transfer with no pixel outstanding: %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_pix = shaded_q.pop_front();
          if (got_pix.color_index !== exp_pix.color_index) begin
            $error("color_index: expected %0d, got %0d", exp_pix.color_index,
                   got_pix.color_index);
            fail_count++;
          end
          if (got_pix.pixel_color !== exp_pix.pixel_color) begin
            $error("pixel_color: expected %h, got %h", exp_pix.pixel_color,
                   got_pix.pixel_color);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_palette_fill();
    test_reset_config();
    test_register_extremes();
    test_load_forwarding();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
